[sv/rational_bezier_curve_lookup_macros.svh]
// Assertion helpers for the curve lookup checker.
`ifndef RATIONAL_BEZIER_CURVE_LOOKUP_MACROS_SVH
`define RATIONAL_BEZIER_CURVE_LOOKUP_MACROS_SVH

// same-cycle implication
`define RBEZ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbez check failed");

// next-cycle implication
`define RBEZ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbez check failed");

`endif

[sv/rbez_pkg.sv]
package rbez_pkg;

  localparam int COORD_W  = 16;
  localparam int WGT_W    = 16;
  localparam int ITER_W   = 5;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int MAX_ITER = 30;
  localparam int MIN_ITER = 6;
  localparam int POS_W    = 32;
  localparam int BASIS_W  = 30;
  localparam int K_W      = 49;
  localparam int DEN_W    = 51;
  localparam int PROD_W   = 65;
  localparam int NUM_W    = 64;
  localparam int TDEN_W   = 67;
  localparam int Q_W      = 16;

  localparam logic [COORD_W-1:0] COORD_ONE = 16'h8000;
  localparam logic [CFG_W-1:0]   POINT_ONE = 32'h8000_8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START  = 3'd0,
    REG_INNER1 = 3'd1,
    REG_INNER2 = 3'd2,
    REG_END    = 3'd3,
    REG_WGT1   = 3'd4,
    REG_WGT2   = 3'd5,
    REG_ITER   = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [POS_W-1:0]   lo;
    logic [POS_W-1:0]   hi;
    logic [POS_W-1:0]   mid;
    logic [COORD_W-1:0] target;
  } tag_t;

  typedef struct packed {
    logic valid;
    tag_t tag;
  } ev_in_t;

  typedef struct packed {
    logic             valid;
    tag_t             tag;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } ev_out_t;

  typedef struct packed {
    logic             valid;
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   q;
  } dv_t;

endpackage

[sv/rational_bezier_curve_lookup.sv]
// Rational cubic Bezier lookup: y for a target x.
// Input beat: in_x_in (UQ1.15, values above 1.0 act as 1.0) on in_valid/in_ready.
// Result beat: out_y_out (UQ1.15, 0..1.0) on out_valid/out_ready, one per input,
// in input order.
// Config: cfg_we/cfg_index/cfg_data write one register per cycle, no read-back;
// write only while no beat is in flight.
// Throughput: one beat per cycle while the output is not stalled. Pipeline:
// 30 bisection units of 7 stages, a 5-stage final evaluation, a rounding
// stage, a 16-stage restoring divider and the output register.
// Iteration units past the configured count pass their bracket unchanged,
// so latency does not depend on iteration_count.
// Reset: pipeline valid bits and the output clear, registers take their defaults.
// Stall: while out_ready is low the result holds; one more result parks in a
// skid register, then the whole pipeline freezes and in_ready drops.
module rational_bezier_curve_lookup (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [rbez_pkg::COORD_W-1:0]       in_x_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rbez_pkg::COORD_W-1:0]       out_y_out,
  input  logic                               cfg_we,
  input  logic [rbez_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rbez_pkg::CFG_W-1:0]         cfg_data
);

  logic [rbez_pkg::CFG_W-1:0]  p0_r, p1_r, p2_r, p3_r;
  logic [rbez_pkg::WGT_W-1:0]  w1_r, w2_r;
  logic [rbez_pkg::ITER_W-1:0] iter_r;
  logic [rbez_pkg::ITER_W-1:0] niter;

  logic en;
  logic push;
  logic [rbez_pkg::COORD_W-1:0] tgt;
  logic [rbez_pkg::COORD_W-1:0] y_cl;

  rbez_pkg::ev_in_t  stg [0:rbez_pkg::MAX_ITER];
  rbez_pkg::ev_out_t ev  [0:rbez_pkg::MAX_ITER];
  rbez_pkg::dv_t     dv  [0:rbez_pkg::Q_W];

  logic                         out_v_r, sk_v_r;
  logic [rbez_pkg::COORD_W-1:0] out_y_r, sk_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_r   <= '0;
      p1_r   <= '0;
      p2_r   <= rbez_pkg::POINT_ONE;
      p3_r   <= rbez_pkg::POINT_ONE;
      w1_r   <= 16'd256;
      w2_r   <= 16'd256;
      iter_r <= 5'd20;
    end else if (cfg_we) begin
      case (cfg_index)
        rbez_pkg::REG_START:  p0_r   <= cfg_data;
        rbez_pkg::REG_INNER1: p1_r   <= cfg_data;
        rbez_pkg::REG_INNER2: p2_r   <= cfg_data;
        rbez_pkg::REG_END:    p3_r   <= cfg_data;
        rbez_pkg::REG_WGT1:   w1_r   <= cfg_data[rbez_pkg::WGT_W-1:0];
        rbez_pkg::REG_WGT2:   w2_r   <= cfg_data[rbez_pkg::WGT_W-1:0];
        rbez_pkg::REG_ITER:   iter_r <= cfg_data[rbez_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (iter_r < rbez_pkg::ITER_W'(rbez_pkg::MIN_ITER)) begin
      niter = rbez_pkg::ITER_W'(rbez_pkg::MIN_ITER);
    end else if (iter_r > rbez_pkg::ITER_W'(rbez_pkg::MAX_ITER)) begin
      niter = rbez_pkg::ITER_W'(rbez_pkg::MAX_ITER);
    end else begin
      niter = iter_r;
    end
    tgt = (in_x_in > rbez_pkg::COORD_ONE) ? rbez_pkg::COORD_ONE : in_x_in;
  end

  assign en       = !sk_v_r;
  assign in_ready = en;
  assign stg[0]   = '{valid: in_valid,
                      tag: '{lo: '0, hi: 32'h8000_0000, mid: 32'h4000_0000, target: tgt}};

  // bisection units
  for (genvar i = 0; i < rbez_pkg::MAX_ITER; i++) begin : g_it
    logic                          c_v_r;
    rbez_pkg::tag_t                c_tag_r;
    logic [rbez_pkg::NUM_W-1:0]    c_num_r;
    logic [rbez_pkg::TDEN_W-1:0]   c_tden_r;
    logic                          lt, act;
    logic [rbez_pkg::POS_W-1:0]    lo_n, hi_n;
    logic [rbez_pkg::POS_W:0]      sum;
    rbez_pkg::tag_t                tag_nxt;
    logic                          nx_v_r;
    rbez_pkg::tag_t                nx_tag_r;

    rbez_eval u_ev (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ev_i  (stg[i]),
      .c0    (p0_r[31:16]),
      .c1    (p1_r[31:16]),
      .c2    (p2_r[31:16]),
      .c3    (p3_r[31:16]),
      .w1    (w1_r),
      .w2    (w2_r),
      .ev_o  (ev[i])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_v_r  <= 1'b0;
        nx_v_r <= 1'b0;
      end else if (en) begin
        c_v_r  <= ev[i].valid;
        nx_v_r <= c_v_r;
      end
    end

    always_comb begin
      lt   = rbez_pkg::TDEN_W'(c_num_r) < c_tden_r;
      act  = rbez_pkg::ITER_W'(i) < niter;
      lo_n = c_tag_r.lo;
      hi_n = c_tag_r.hi;
      if (act) begin
        if (lt) begin
          lo_n = c_tag_r.mid;
        end else begin
          hi_n = c_tag_r.mid;
        end
      end
      sum     = (rbez_pkg::POS_W+1)'(lo_n) + (rbez_pkg::POS_W+1)'(hi_n);
      tag_nxt = '{lo: lo_n, hi: hi_n, mid: sum[rbez_pkg::POS_W:1], target: c_tag_r.target};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c_tag_r  <= ev[i].tag;
        c_num_r  <= ev[i].num;
        c_tden_r <= rbez_pkg::TDEN_W'(ev[i].den) * rbez_pkg::TDEN_W'(ev[i].tag.target);
        nx_tag_r <= tag_nxt;
      end
    end

    assign stg[i+1] = '{valid: nx_v_r, tag: nx_tag_r};
  end

  // final evaluation on y
  rbez_eval u_ev_y (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ev_i  (stg[rbez_pkg::MAX_ITER]),
    .c0    (p0_r[15:0]),
    .c1    (p1_r[15:0]),
    .c2    (p2_r[15:0]),
    .c3    (p3_r[15:0]),
    .w1    (w1_r),
    .w2    (w2_r),
    .ev_o  (ev[rbez_pkg::MAX_ITER])
  );

  // round half up: divide num + den/2 by den
  logic          rd_v_r;
  rbez_pkg::dv_t rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else if (en) begin
      rd_v_r <= ev[rbez_pkg::MAX_ITER].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_r.rem <= ev[rbez_pkg::MAX_ITER].num
                + rbez_pkg::NUM_W'(ev[rbez_pkg::MAX_ITER].den >> 1);
      rd_r.den <= ev[rbez_pkg::MAX_ITER].den;
      rd_r.q   <= '0;
    end
  end

  assign dv[0] = '{valid: rd_v_r, rem: rd_r.rem, den: rd_r.den, q: rd_r.q};

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < rbez_pkg::Q_W; j++) begin : g_dv
    localparam int BIT = rbez_pkg::Q_W - 1 - j;
    logic [rbez_pkg::TDEN_W-1:0] dsh;
    logic                        ge;
    logic [rbez_pkg::NUM_W-1:0]  rem_nxt;
    logic [rbez_pkg::Q_W-1:0]    q_nxt;
    logic                        s_v_r;
    rbez_pkg::dv_t               s_r;

    always_comb begin
      dsh     = rbez_pkg::TDEN_W'(dv[j].den) << BIT;
      ge      = rbez_pkg::TDEN_W'(dv[j].rem) >= dsh;
      rem_nxt = ge ? (dv[j].rem - dsh[rbez_pkg::NUM_W-1:0]) : dv[j].rem;
      q_nxt   = dv[j].q;
      q_nxt[BIT] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_v_r <= 1'b0;
      end else if (en) begin
        s_v_r <= dv[j].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r.rem <= rem_nxt;
        s_r.den <= dv[j].den;
        s_r.q   <= q_nxt;
      end
    end

    assign dv[j+1] = '{valid: s_v_r, rem: s_r.rem, den: s_r.den, q: s_r.q};
  end

  assign y_cl = (dv[rbez_pkg::Q_W].q > rbez_pkg::COORD_ONE) ? rbez_pkg::COORD_ONE
                                                            : dv[rbez_pkg::Q_W].q;
  assign push = en && dv[rbez_pkg::Q_W].valid;

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      if (!out_v_r || out_ready) begin
        if (sk_v_r) begin
          out_v_r <= 1'b1;
          sk_v_r  <= 1'b0;
        end else begin
          out_v_r <= push;
        end
      end else if (push) begin
        sk_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ready) begin
      out_y_r <= sk_v_r ? sk_y_r : y_cl;
    end
    if (out_v_r && !out_ready && push) begin
      sk_y_r <= y_cl;
    end
  end

  assign out_valid = out_v_r;
  assign out_y_out = out_y_r;

endmodule

[sv/rbez_eval.sv]
module rbez_eval (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  rbez_pkg::ev_in_t                ev_i,
  input  logic [rbez_pkg::COORD_W-1:0]    c0,
  input  logic [rbez_pkg::COORD_W-1:0]    c1,
  input  logic [rbez_pkg::COORD_W-1:0]    c2,
  input  logic [rbez_pkg::COORD_W-1:0]    c3,
  input  logic [rbez_pkg::WGT_W-1:0]      w1,
  input  logic [rbez_pkg::WGT_W-1:0]      w2,
  output rbez_pkg::ev_out_t               ev_o
);

  logic [4:0]            vld_r;
  rbez_pkg::tag_t        tag_r [0:4];

  // stage 1
  logic [29:0] t;
  logic [30:0] u;
  logic [59:0] tt;
  logic [61:0] uu;
  logic [29:0] t_r, t2_r;
  logic [30:0] u_r, u2_r;
  // stage 2
  logic [59:0] tt3;
  logic [61:0] uu3;
  logic [60:0] ut, tu;
  logic [29:0] t3_r;
  logic [30:0] u3_r, a1_r, a2_r;
  // stage 3
  logic [32:0] b1, b2;
  logic [rbez_pkg::K_W-1:0] k0_r, k1_r, k2_r, k3_r;
  // stage 4
  logic [rbez_pkg::DEN_W-1:0]  dsum;
  logic [rbez_pkg::DEN_W-1:0]  den4_r, den5_r;
  logic [rbez_pkg::PROD_W-1:0] p0_r, p1_r, p2_r, p3_r;
  // stage 5
  logic [rbez_pkg::PROD_W+1:0] nsum;
  logic [rbez_pkg::NUM_W-1:0]  num_r;

  always_comb begin
    t    = ev_i.tag.mid[30:1];
    u    = 31'h4000_0000 - 31'(t);
    tt   = t * t;
    uu   = 62'(u) * 62'(u);
    tt3  = t2_r * t_r;
    uu3  = 62'(u2_r) * 62'(u_r);
    ut   = 61'(u2_r) * 61'(t_r);
    tu   = 61'(u_r) * 61'(t2_r);
    b1   = {1'b0, a1_r, 1'b0} + 33'(a1_r);
    b2   = {1'b0, a2_r, 1'b0} + 33'(a2_r);
    dsum = rbez_pkg::DEN_W'(k0_r) + rbez_pkg::DEN_W'(k1_r)
         + rbez_pkg::DEN_W'(k2_r) + rbez_pkg::DEN_W'(k3_r);
    nsum = (rbez_pkg::PROD_W+2)'(p0_r) + (rbez_pkg::PROD_W+2)'(p1_r)
         + (rbez_pkg::PROD_W+2)'(p2_r) + (rbez_pkg::PROD_W+2)'(p3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], ev_i.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= ev_i.tag;
      tag_r[1] <= tag_r[0];
      tag_r[2] <= tag_r[1];
      tag_r[3] <= tag_r[2];
      tag_r[4] <= tag_r[3];
      t_r    <= t;
      u_r    <= u;
      t2_r   <= tt[59:30];
      u2_r   <= uu[60:30];
      t3_r   <= tt3[59:30];
      u3_r   <= uu3[60:30];
      a1_r   <= ut[60:30];
      a2_r   <= tu[60:30];
      k0_r   <= rbez_pkg::K_W'(u3_r) << 8;
      k3_r   <= rbez_pkg::K_W'(t3_r) << 8;
      k1_r   <= rbez_pkg::K_W'(b1) * rbez_pkg::K_W'(w1);
      k2_r   <= rbez_pkg::K_W'(b2) * rbez_pkg::K_W'(w2);
      den4_r <= (dsum == '0) ? rbez_pkg::DEN_W'(1) : dsum;
      p0_r   <= rbez_pkg::PROD_W'(k0_r) * rbez_pkg::PROD_W'(c0);
      p1_r   <= rbez_pkg::PROD_W'(k1_r) * rbez_pkg::PROD_W'(c1);
      p2_r   <= rbez_pkg::PROD_W'(k2_r) * rbez_pkg::PROD_W'(c2);
      p3_r   <= rbez_pkg::PROD_W'(k3_r) * rbez_pkg::PROD_W'(c3);
      den5_r <= den4_r;
      num_r  <= nsum[rbez_pkg::NUM_W-1:0];
    end
  end

  assign ev_o = '{valid: vld_r[4], tag: tag_r[4], num: num_r, den: den5_r};

endmodule

[sv/rbez_checker.sv]
`include "rational_bezier_curve_lookup_macros.svh"

module rbez_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [rbez_pkg::COORD_W-1:0] out_y_out
);

  `RBEZ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `RBEZ_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_y_out))
  `RBEZ_ASSERT_SAME(a_y_range, out_valid, out_y_out <= rbez_pkg::COORD_ONE)
  `RBEZ_ASSERT_SAME(a_stall_needs_out, !in_ready, out_valid)
  `RBEZ_ASSERT_SAME(a_reset_clear, rst_n && $past(!rst_n), !out_valid && in_ready)

endmodule

bind rational_bezier_curve_lookup rbez_checker u_rbez_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_y_out (out_y_out)
);

[dv/rational_bezier_curve_lookup_tb.sv]
`timescale 1ns / 1ps

module rational_bezier_curve_lookup_tb;

  localparam int LATENCY   = 233;
  localparam int IDLE_LIMIT = 4000;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic [rbez_pkg::COORD_W-1:0]   in_x_in;
  logic                           out_valid;
  logic                           out_ready;
  logic [rbez_pkg::COORD_W-1:0]   out_y_out;
  logic                           cfg_we;
  logic [rbez_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rbez_pkg::CFG_W-1:0]     cfg_data;

  rational_bezier_curve_lookup DUT (.*);

  // shadow registers
  logic [31:0] pt [4];
  logic [15:0] wgt1, wgt2;
  logic [4:0]  iters;

  logic [rbez_pkg::COORD_W-1:0] y_expected [$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void eval_curve(input longint unsigned t_exact,
                                     output longint unsigned nx,
                                     output longint unsigned ny,
                                     output longint unsigned den);
    longint unsigned t, u, t2, t3, u2, u3, k0, k1, k2, k3;
    t  = t_exact >> 1;
    u  = (64'd1 << 30) - t;
    t2 = (t * t) >> 30;
    t3 = (t2 * t) >> 30;
    u2 = (u * u) >> 30;
    u3 = (u2 * u) >> 30;
    k0 = u3 * 256;
    k1 = 3 * ((u2 * t) >> 30) * wgt1;
    k2 = 3 * ((u * t2) >> 30) * wgt2;
    k3 = t3 * 256;
    den = k0 + k1 + k2 + k3;
    if (den == 0) den = 1;
    nx = k0 * pt[0][31:16] + k1 * pt[1][31:16] + k2 * pt[2][31:16] + k3 * pt[3][31:16];
    ny = k0 * pt[0][15:0] + k1 * pt[1][15:0] + k2 * pt[2][15:0] + k3 * pt[3][15:0];
  endfunction

  function automatic logic [rbez_pkg::COORD_W-1:0] lookup_y(
      input logic [rbez_pkg::COORD_W-1:0] x);
    longint unsigned target, lo, hi, mid, nx, ny, den, y;
    int n;
    target = x;
    if (target > rbez_pkg::COORD_ONE) target = rbez_pkg::COORD_ONE;
    n = iters;
    if (n < rbez_pkg::MIN_ITER) n = rbez_pkg::MIN_ITER;
    if (n > rbez_pkg::MAX_ITER) n = rbez_pkg::MAX_ITER;
    lo = 0;
    hi = 64'd1 << 31;
    for (int i = 0; i < n; i++) begin
      mid = (lo + hi) >> 1;
      eval_curve(mid, nx, ny, den);
      if (nx < target * den) lo = mid;
      else hi = mid;
    end
    eval_curve((lo + hi) >> 1, nx, ny, den);
    y = (ny + (den >> 1)) / den;
    if (y > rbez_pkg::COORD_ONE) y = rbez_pkg::COORD_ONE;
    return y[rbez_pkg::COORD_W-1:0];
  endfunction

  task automatic write_reg(input rbez_pkg::cfg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      rbez_pkg::REG_START:  pt[0] = val;
      rbez_pkg::REG_INNER1: pt[1] = val;
      rbez_pkg::REG_INNER2: pt[2] = val;
      rbez_pkg::REG_END:    pt[3] = val;
      rbez_pkg::REG_WGT1:   wgt1 = val[15:0];
      rbez_pkg::REG_WGT2:   wgt2 = val[15:0];
      rbez_pkg::REG_ITER:   iters = val[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_x(input logic [rbez_pkg::COORD_W-1:0] x);
    @(negedge clk);
    in_valid <= 1'b1;
    in_x_in  <= x;
    do @(posedge clk); while (!in_ready);
    y_expected.push_back(lookup_y(x));
  endtask

  task automatic pause_input(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic drain;
    pause_input(1);
    while (y_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_x();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'($urandom());
    if (r == 1) return rbez_pkg::COORD_ONE;
    if (r == 2) return 16'd0;
    return 16'($urandom_range(0, 32768));
  endfunction

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd51200;
      default: return 16'($urandom_range(0, 51200));
    endcase
  endfunction

  task automatic burst_items(input int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && left > 0; i++, left--) send_x(rand_x());
      if ($urandom_range(0, 2) != 0) pause_input($urandom_range(1, 12));
    end
  endtask

  task automatic test_reset_curve;
    logic [15:0] edge_x [] = '{16'h0000, 16'h0001, 16'h8000, 16'h8001, 16'hFFFF,
                               16'h4000, 16'h7FFF, 16'h2000, 16'h6000, 16'hAAAA,
                               16'h5555, 16'h0100, 16'h00FF};
    foreach (edge_x[i]) send_x(edge_x[i]);
    drain();
  endtask

  task automatic test_extreme_config;
    write_reg(rbez_pkg::REG_START, 32'h0000_0000);
    write_reg(rbez_pkg::REG_INNER1, 32'hFFFF_FFFF);
    write_reg(rbez_pkg::REG_INNER2, 32'h0000_FFFF);
    write_reg(rbez_pkg::REG_END, 32'hFFFF_FFFF);
    write_reg(rbez_pkg::REG_WGT1, 32'h0000_FFFF);
    write_reg(rbez_pkg::REG_WGT2, 32'h0000_0000);
    write_reg(rbez_pkg::REG_ITER, 32'd0);
    send_x(16'h0000); send_x(16'h8000); send_x(16'hFFFF); send_x(16'h3000);
    drain();
    write_reg(rbez_pkg::REG_WGT1, 32'd0);
    write_reg(rbez_pkg::REG_ITER, 32'd31);
    send_x(16'h0000); send_x(16'h8000); send_x(16'h4000); send_x(16'hC000);
    drain();
  endtask

  task automatic test_random_curves(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      write_reg(rbez_pkg::REG_START, (p % 3 == 0) ? 32'd0 : $urandom());
      write_reg(rbez_pkg::REG_INNER1, $urandom());
      write_reg(rbez_pkg::REG_INNER2, $urandom());
      write_reg(rbez_pkg::REG_END, (p % 3 == 0) ? rbez_pkg::POINT_ONE : $urandom());
      write_reg(rbez_pkg::REG_WGT1, {16'($urandom()), rand_weight()});
      write_reg(rbez_pkg::REG_WGT2, {16'($urandom()), rand_weight()});
      case (p % 4)
        0: write_reg(rbez_pkg::REG_ITER, {27'($urandom()), 5'd6});
        1: write_reg(rbez_pkg::REG_ITER, {27'($urandom()), 5'd30});
        default: write_reg(rbez_pkg::REG_ITER, $urandom());
      endcase
      burst_items(per_phase);
      drain();
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b1;
    else if ($urandom_range(0, 3) == 0) out_ready <= ($urandom_range(0, 2) == 0);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (y_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat y_out=%h", out_y_out);
      end else begin
        if (out_y_out !== y_expected[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("y_out mismatch: expected %h actual %h", y_expected[0], out_y_out);
        end
        void'(y_expected.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (!in_valid && y_expected.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_x_in = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pt[0] = 32'd0;
    pt[1] = 32'd0;
    pt[2] = rbez_pkg::POINT_ONE;
    pt[3] = rbez_pkg::POINT_ONE;
    wgt1 = 16'd256;
    wgt2 = 16'd256;
    iters = 5'd20;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_curve();
    test_extreme_config();
    test_random_curves(8, 170);
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && y_expected.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
